// ----- src/argtok_pkg.sv -----
package argtok_pkg;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;

  localparam logic [7:0] END_MARK_BYTE = 8'h00;

  typedef struct packed {
    logic dq;
    logic sq;
    logic br;
    logic esc;
    logic open;
  } flags_t;

  localparam flags_t FLAGS_CLEAR = '{dq: 1'b0, sq: 1'b0, br: 1'b0, esc: 1'b0, open: 1'b0};

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       token_end;
  } result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_FF) || (b == CH_LF) ||
           (b == CH_CR) || (b == CH_TAB) || (b == CH_VT);
  endfunction

endpackage

// ----- src/argtok_step.sv -----
module argtok_step (
  input  logic [7:0]       byte_i,
  input  logic             eos_i,
  input  argtok_pkg::flags_t flags_i,
  output argtok_pkg::flags_t flags_o,
  output argtok_pkg::result_t res_o
);

  logic blank;

  assign blank = argtok_pkg::is_blank(byte_i);

  always_comb begin
    flags_o = flags_i;
    res_o.valid     = 1'b1;
    res_o.data      = byte_i;
    res_o.token_end = 1'b0;

    priority if (eos_i) begin
      // terminator closes any open token, even inside quotes
      flags_o         = argtok_pkg::FLAGS_CLEAR;
      res_o.valid     = flags_i.open;
      res_o.data      = argtok_pkg::END_MARK_BYTE;
      res_o.token_end = 1'b1;
    end else if (!flags_i.open && blank) begin
      // skip whitespace between tokens
      res_o.valid = 1'b0;
    end else begin
      flags_o.open = 1'b1;
      priority if (byte_i == argtok_pkg::CH_DQUOTE && !flags_i.sq && !flags_i.esc) begin
        flags_o.dq = !flags_i.dq;
      end else if (byte_i == argtok_pkg::CH_SQUOTE && !flags_i.dq && !flags_i.esc) begin
        flags_o.sq = !flags_i.sq;
      end else if (byte_i == argtok_pkg::CH_LBRACK && !flags_i.dq && !flags_i.sq &&
                   !flags_i.br && !flags_i.esc) begin
        flags_o.br = 1'b1;
      end else if (byte_i == argtok_pkg::CH_RBRACK && !flags_i.dq && !flags_i.sq &&
                   flags_i.br && !flags_i.esc) begin
        flags_o.br = 1'b0;
      end else if (byte_i == argtok_pkg::CH_BSLASH) begin
        flags_o.esc = !flags_i.esc;
      end else if (!flags_i.dq && !flags_i.sq && !flags_i.br && !flags_i.esc && blank) begin
        flags_o.open    = 1'b0;
        res_o.data      = argtok_pkg::END_MARK_BYTE;
        res_o.token_end = 1'b1;
      end else begin
        flags_o.esc = flags_i.esc;
      end
      // any passed byte other than a backslash drops a pending escape
      if (byte_i != argtok_pkg::CH_BSLASH) begin
        flags_o.esc = 1'b0;
      end
    end
  end

endmodule

// ----- src/argtok_oreg.sv -----
module argtok_oreg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  argtok_pkg::result_t res_i,
  input  logic                out_stall,
  output logic                free_o,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_token_end
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       end_r;

  assign free_o = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (load_i) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      data_r <= res_i.data;
      end_r  <= res_i.token_end;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = data_r;
  assign out_token_end = end_r;

endmodule

// ----- src/argument_tokenizer_top.sv -----
// channel   direction  handshake               payload
// in_       input      in_valid / in_stall     in_byte[7:0], in_end_of_string
// out_      output     out_valid / out_stall   out_byte[7:0], out_token_end
//
// One word can be taken every cycle while in_stall is low; its result, if any,
// goes from the input register into the output register and leaves when out_stall
// is low. The single pass of flag logic between the two registers sets the rate.
// rst_n (synchronous, active low) clears all five flags and both valid bits.
// out_stall backs up through in_stall only when a word that makes a result
// finds the output register still holding an untaken result.
module argument_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_token_end
);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_eos_r;

  // tokenizer flags
  argtok_pkg::flags_t flags_r, flags_nxt;

  argtok_pkg::result_t res;
  logic oreg_free;
  logic consume;
  logic accept;

  // retire the held word once its result has somewhere to go
  assign consume  = in_valid_r && (!res.valid || oreg_free);
  assign in_stall = in_valid_r && !consume;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r && !consume;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // hold the payload until a new word is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte;
      in_eos_r  <= in_end_of_string;
    end
  end

  argtok_step u_step (
    .byte_i  (in_byte_r),
    .eos_i   (in_eos_r),
    .flags_i (flags_r),
    .flags_o (flags_nxt),
    .res_o   (res)
  );

  // advance the flags only when the word retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= argtok_pkg::FLAGS_CLEAR;
    end else if (consume) begin
      flags_r <= flags_nxt;
    end
  end

  argtok_oreg u_oreg (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_i        (consume && res.valid),
    .res_i         (res),
    .out_stall     (out_stall),
    .free_o        (oreg_free),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_token_end (out_token_end)
  );

endmodule

// ----- src/argtok_chk.sv -----
module argtok_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_token_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_token_end))
    else $error("output word changed while stalled");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_end |-> out_byte == argtok_pkg::END_MARK_BYTE)
    else $error("end marker carries a nonzero byte");

  a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_token_end) ##1 out_valid |-> !out_token_end)
    else $error("two end markers in a row");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("out_valid set right after reset");

endmodule

bind argument_tokenizer_top argtok_chk u_argtok_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_token_end (out_token_end)
);
